@@ design/ics_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the indexed char sequence store.
// No dependencies; imported by every other file of the block.
package ics_pkg;

	localparam int CAPACITY = 64;
	localparam int IDX_W    = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);

	localparam int OPC_W = 4;
	localparam int CH_W  = 8;
	localparam int POS_W = 7;
	localparam int ST_W  = 2;
	localparam int LEN_W = 7;

	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic [CH_W-1:0]  byte_t;
	typedef logic [CMP_W-1:0] cmp_t;

	typedef enum logic [OPC_W-1:0] {
		OP_PUSH_FRONT = 4'd0,
		OP_PUSH_BACK  = 4'd1,
		OP_POP_FRONT  = 4'd2,
		OP_POP_BACK   = 4'd3,
		OP_INSERT     = 4'd4,
		OP_SORTED     = 4'd5,
		OP_REMOVE     = 4'd6,
		OP_REPLACE    = 4'd7,
		OP_READ       = 4'd8,
		OP_FIRST      = 4'd9,
		OP_LAST       = 4'd10,
		OP_CLEAR      = 4'd11
	} opcode_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [2:0] {
		CM_HOLD,
		CM_INSERT,
		CM_SORTED,
		CM_REMOVE,
		CM_WRITE
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t mode;
		cmp_t       at;
		cmp_t       cnt;
		byte_t      ch;
	} cell_cmd_t;

endpackage

@@ design/ics_req_if.sv @@
`timescale 1ns / 1ps
// Request channel of the store: valid/ready handshake with opcode, byte and position.
// Depends on ics_pkg.
interface ics_req_if import ics_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [OPC_W-1:0] opcode;
	logic [CH_W-1:0]  ch;
	logic [POS_W-1:0] position;

	modport source (output valid, opcode, ch, position, input ready);
	modport sink   (input valid, opcode, ch, position, output ready);
endinterface

@@ design/ics_rsp_if.sv @@
`timescale 1ns / 1ps
// Response channel of the store: valid/ready handshake with byte, status and length.
// Depends on ics_pkg.
interface ics_rsp_if import ics_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [CH_W-1:0]  read_byte;
	logic [ST_W-1:0]  status;
	logic [LEN_W-1:0] length_now;

	modport source (output valid, read_byte, status, length_now, input ready);
	modport sink   (input valid, read_byte, status, length_now, output ready);
endinterface

@@ design/ics_cell.sv @@
`timescale 1ns / 1ps
// One storage cell of the chain: holds a byte, takes from a neighbour on shifts.
// Depends on ics_pkg.
module ics_cell import ics_pkg::*; (
	input  logic            clk,
	input  logic [IDX_W-1:0] idx,
	input  cell_cmd_t       cmd,
	input  byte_t           left,
	input  byte_t           right,
	input  logic            found_in,
	output logic            found_out,
	output byte_t           value
);
	byte_t value_q;
	byte_t value_d;
	cmp_t  idx_e;
	logic  smaller;
	logic  here;
	logic  past;

	assign idx_e     = CMP_W'(idx);
	assign smaller   = (idx_e < cmd.cnt) && (value_q < cmd.ch);
	assign found_out = found_in | ~smaller;
	assign value     = value_q;

	always_comb begin
		if (cmd.mode == CM_SORTED) begin
			here = ~found_in & ~smaller;
			past = found_in;
		end else begin
			here = (idx_e == cmd.at);
			past = (idx_e > cmd.at);
		end
	end

	always_comb begin
		value_d = value_q;
		case (cmd.mode) inside
			CM_INSERT, CM_SORTED: begin
				if (here)
					value_d = cmd.ch;
				else if (past)
					value_d = left;
			end
			CM_REMOVE: begin
				if (here || past)
					value_d = right;
			end
			CM_WRITE: begin
				if (here)
					value_d = cmd.ch;
			end
			default: value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end
endmodule

@@ design/ics_chain.sv @@
`timescale 1ns / 1ps
// Row of CAPACITY cells with neighbour links and the sorted-position search chain.
// Depends on ics_pkg and ics_cell.
module ics_chain import ics_pkg::*; (
	input  logic                     clk,
	input  cell_cmd_t                cmd,
	output logic [CAPACITY-1:0][CH_W-1:0] data
);
	logic [CAPACITY:0] found;

	assign found[0] = 1'b0;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		byte_t left_v;
		byte_t right_v;

		if (i == 0) begin : g_first
			assign left_v = '0;
		end else begin : g_mid_l
			assign left_v = data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_v = '0;
		end else begin : g_mid_r
			assign right_v = data[i+1];
		end

		ics_cell u_cell (
			.clk       (clk),
			.idx       (IDX_W'(i)),
			.cmd       (cmd),
			.left      (left_v),
			.right     (right_v),
			.found_in  (found[i]),
			.found_out (found[i+1]),
			.value     (data[i])
		);
	end
endmodule

@@ design/indexed_char_sequence_store_core.sv @@
`timescale 1ns / 1ps
// Top level of the indexed char sequence store: decode, length and response register.
// Depends on ics_pkg, ics_req_if, ics_rsp_if and ics_chain.
//
// Usage:
//   req carries one operation per transaction (opcode, ch, position); rsp returns
//   exactly one transaction per request (read_byte, status, length_now), in order.
//   Every cell of the chain compares its own index (and, for sorted insert, its
//   byte) in parallel and shifts, writes or holds at the same edge; the sorted
//   position ripples along the chain as a one-bit found flag.
//   The response is registered and valid the cycle after the request is accepted.
//   Throughput: one operation per cycle while rsp.ready stays high.
//   The single response register decouples the sides: req.ready is high when
//   the register is empty or is being drained in the same cycle.
//   Stall: with rsp.valid high and rsp.ready low, the response holds and req is
//   refused until it is taken.
//   Reset: arst_n clears the length to zero and drops rsp.valid; stored bytes
//   are not cleared and are only read after being written.
module indexed_char_sequence_store_core import ics_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	ics_req_if.sink   req,
	ics_rsp_if.source rsp
);
	logic [CNT_W-1:0]            count_q;
	logic [CNT_W-1:0]            count_d;
	logic                        rsp_valid_q;
	byte_t                       rd_byte_q;
	status_t                     status_q;
	logic [LEN_W-1:0]            len_q;
	logic                        accept;
	cell_cmd_t                   cmd;
	logic [CAPACITY-1:0][CH_W-1:0] data;
	cmp_t                        pos_e;
	cmp_t                        cnt_e;
	cmp_t                        cnt_d_e;
	cmp_t                        rd_idx;
	logic                        rd_sel;
	logic                        full;
	logic                        empty;
	status_t                     status_d;
	cell_mode_t                  mode;
	cmp_t                        at;
	byte_t                       rd_byte_d;

	assign req.ready = ~rsp_valid_q | rsp.ready;
	assign accept    = req.valid & req.ready;

	assign pos_e = CMP_W'(req.position);
	assign cnt_e = CMP_W'(count_q);
	assign full  = (cnt_e >= CMP_W'(CAPACITY));
	assign empty = (count_q == '0);

	always_comb begin
		status_d = ST_OK;
		mode     = CM_HOLD;
		at       = '0;
		count_d  = count_q;
		rd_sel   = 1'b0;
		rd_idx   = '0;
		unique case (opcode_t'(req.opcode)) inside
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					mode    = CM_INSERT;
					at      = (opcode_t'(req.opcode) == OP_PUSH_BACK) ? cnt_e : '0;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					mode    = CM_REMOVE;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty)
					status_d = ST_EMPTY;
				else
					count_d = count_q - CNT_W'(1);
			end
			OP_INSERT: begin
				if (pos_e > cnt_e) begin
					status_d = ST_RANGE;
				end else if (full) begin
					status_d = ST_FULL;
				end else begin
					mode    = CM_INSERT;
					at      = pos_e;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_SORTED: begin
				if (full) begin
					status_d = ST_FULL;
				end else begin
					mode    = CM_SORTED;
					count_d = count_q + CNT_W'(1);
				end
			end
			OP_REMOVE: begin
				if (pos_e >= cnt_e) begin
					status_d = ST_RANGE;
				end else begin
					mode    = CM_REMOVE;
					at      = pos_e;
					count_d = count_q - CNT_W'(1);
				end
			end
			OP_REPLACE: begin
				if (pos_e >= cnt_e) begin
					status_d = ST_RANGE;
				end else begin
					mode = CM_WRITE;
					at   = pos_e;
				end
			end
			OP_READ: begin
				if (pos_e >= cnt_e) begin
					status_d = ST_RANGE;
				end else begin
					rd_sel = 1'b1;
					rd_idx = pos_e;
				end
			end
			OP_FIRST: begin
				if (empty)
					status_d = ST_EMPTY;
				else
					rd_sel = 1'b1;
			end
			OP_LAST: begin
				if (empty) begin
					status_d = ST_EMPTY;
				end else begin
					rd_sel = 1'b1;
					rd_idx = cnt_e - CMP_W'(1);
				end
			end
			OP_CLEAR: count_d = '0;
			default: status_d = ST_OK;
		endcase
	end

	always_comb begin
		cmd.mode = accept ? mode : CM_HOLD;
		cmd.at   = at;
		cmd.cnt  = cnt_e;
		cmd.ch   = req.ch;
	end

	assign rd_byte_d = rd_sel ? data[rd_idx[IDX_W-1:0]] : '0;
	assign cnt_d_e   = CMP_W'(count_d);

	ics_chain u_chain (
		.clk  (clk),
		.cmd  (cmd),
		.data (data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q     <= count_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rd_byte_q <= rd_byte_d;
			status_q  <= status_d;
			len_q     <= cnt_d_e[LEN_W-1:0];
		end
	end

	assign rsp.valid      = rsp_valid_q;
	assign rsp.read_byte  = rd_byte_q;
	assign rsp.status     = status_q;
	assign rsp.length_now = len_q;
endmodule

@@ design/ics_checker.sv @@
`timescale 1ns / 1ps
// Port-level checks on the store's response channel, bound to the top level.
// Depends on ics_pkg and indexed_char_sequence_store_core.
module ics_checker import ics_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             req_valid,
	input logic             req_ready,
	input logic             rsp_valid,
	input logic             rsp_ready,
	input logic [CH_W-1:0]  read_byte,
	input logic [ST_W-1:0]  status,
	input logic [LEN_W-1:0] length_now
);
	localparam cmp_t CAP_E = CMP_W'(CAPACITY);

	a_accept_gives_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> rsp_valid)
		else $error("accepted request produced no response");

	a_full_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_FULL |-> length_now == CAP_E[LEN_W-1:0])
		else $error("full status with length below capacity");

	a_empty_len: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_EMPTY |-> length_now == '0)
		else $error("empty status with nonzero length");

	a_byte_only_ok: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && read_byte != '0 |-> status == ST_OK)
		else $error("nonzero byte with failing status");

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_byte) && $stable(status)
			&& $stable(length_now))
		else $error("stalled response changed");
endmodule

bind indexed_char_sequence_store_core ics_checker u_ics_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.req_valid  (req.valid),
	.req_ready  (req.ready),
	.rsp_valid  (rsp.valid),
	.rsp_ready  (rsp.ready),
	.read_byte  (rsp.read_byte),
	.status     (rsp.status),
	.length_now (rsp.length_now)
);

@@ bench/indexed_char_sequence_store_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for indexed_char_sequence_store_core: a shadow byte store predicts
// every response to directed and random operations under varied idling on both channels.
// Depends on ics_pkg, ics_req_if, ics_rsp_if and the core.
module indexed_char_sequence_store_core_tb;
	import ics_pkg::*;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int PHASE_ITEMS    = 460;

	typedef struct {
		byte_t            read_byte;
		status_t          status;
		logic [LEN_W-1:0] length_now;
	} store_rsp_t;

	class byte_store_scoreboard;
		byte_t      shadow_cells [CAPACITY];
		int         shadow_len;
		store_rsp_t expected_rsp_q [$];
		int         mismatches;

		function new();
			shadow_len = 0;
			mismatches = 0;
		endfunction

		function status_t place_byte(int at, byte_t b);
			if (at > shadow_len)
				return ST_RANGE;
			if (shadow_len >= CAPACITY)
				return ST_FULL;
			for (int i = shadow_len; i > at; i--)
				shadow_cells[i] = shadow_cells[i-1];
			shadow_cells[at] = b;
			shadow_len++;
			return ST_OK;
		endfunction

		function void drop_byte(int at);
			for (int i = at; i + 1 < shadow_len; i++)
				shadow_cells[i] = shadow_cells[i+1];
			shadow_len--;
		endfunction

		function void note_request(logic [OPC_W-1:0] op, byte_t ch, logic [POS_W-1:0] pos);
			store_rsp_t rsp_exp;
			int         k;
			int         at;
			at = int'(pos);
			rsp_exp.read_byte = '0;
			rsp_exp.status    = ST_OK;
			case (op)
				OP_PUSH_FRONT: rsp_exp.status = place_byte(0, ch);
				OP_PUSH_BACK:  rsp_exp.status = place_byte(shadow_len, ch);
				OP_POP_FRONT: begin
					if (shadow_len == 0)
						rsp_exp.status = ST_EMPTY;
					else
						drop_byte(0);
				end
				OP_POP_BACK: begin
					if (shadow_len == 0)
						rsp_exp.status = ST_EMPTY;
					else
						shadow_len--;
				end
				OP_INSERT: rsp_exp.status = place_byte(at, ch);
				OP_SORTED: begin
					if (shadow_len >= CAPACITY) begin
						rsp_exp.status = ST_FULL;
					end else begin
						k = 0;
						while (k < shadow_len && shadow_cells[k] < ch)
							k++;
						rsp_exp.status = place_byte(k, ch);
					end
				end
				OP_REMOVE: begin
					if (at >= shadow_len)
						rsp_exp.status = ST_RANGE;
					else
						drop_byte(at);
				end
				OP_REPLACE: begin
					if (at >= shadow_len)
						rsp_exp.status = ST_RANGE;
					else
						shadow_cells[at] = ch;
				end
				OP_READ: begin
					if (at >= shadow_len)
						rsp_exp.status = ST_RANGE;
					else
						rsp_exp.read_byte = shadow_cells[at];
				end
				OP_FIRST: begin
					if (shadow_len == 0)
						rsp_exp.status = ST_EMPTY;
					else
						rsp_exp.read_byte = shadow_cells[0];
				end
				OP_LAST: begin
					if (shadow_len == 0)
						rsp_exp.status = ST_EMPTY;
					else
						rsp_exp.read_byte = shadow_cells[shadow_len-1];
				end
				OP_CLEAR: shadow_len = 0;
				default: ;
			endcase
			rsp_exp.length_now = LEN_W'(shadow_len);
			expected_rsp_q.push_back(rsp_exp);
		endfunction

		function void check_response(byte_t rb, logic [ST_W-1:0] st, logic [LEN_W-1:0] len);
			store_rsp_t rsp_exp;
			if (expected_rsp_q.size() == 0) begin
				$error("unexpected transaction: read_byte %0d status %0d length_now %0d",
					rb, st, len);
				mismatches++;
				return;
			end
			rsp_exp = expected_rsp_q.pop_front();
			if (rb !== rsp_exp.read_byte) begin
				$error("read_byte: expected %0d, actual %0d", rsp_exp.read_byte, rb);
				mismatches++;
			end
			if (st !== rsp_exp.status) begin
				$error("status: expected %0d, actual %0d", rsp_exp.status, st);
				mismatches++;
			end
			if (len !== rsp_exp.length_now) begin
				$error("length_now: expected %0d, actual %0d", rsp_exp.length_now, len);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	int   src_idle_pct   = 0;
	int   sink_stall_pct = 0;
	int   idle_cycles    = 0;

	byte_store_scoreboard sb = new();

	ics_req_if req ();
	ics_rsp_if rsp ();

	indexed_char_sequence_store_core u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		rsp.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp.valid && rsp.ready)
				sb.check_response(rsp.read_byte, rsp.status, rsp.length_now);
			rsp.ready <= ($urandom_range(99) >= sink_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req.valid && req.ready) || (rsp.valid && rsp.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("indexed_char_sequence_store_core_tb NOT OK");
			$finish;
		end
	end

	task automatic send_request(logic [OPC_W-1:0] op, byte_t ch, logic [POS_W-1:0] pos);
		if ($urandom_range(99) < src_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < src_idle_pct)
				@(posedge clk);
		end
		req.valid    <= 1'b1;
		req.opcode   <= op;
		req.ch       <= ch;
		req.position <= pos;
		@(posedge clk);
		while (!req.ready)
			@(posedge clk);
		sb.note_request(op, ch, pos);
	endtask

	function automatic logic [POS_W-1:0] pick_position(int len);
		int r;
		r = $urandom_range(99);
		if (r < 70)
			return POS_W'($urandom_range(len));
		if (r < 80)
			return POS_W'(len);
		return POS_W'($urandom_range(127));
	endfunction

	task automatic send_fill_op();
		int r;
		r = $urandom_range(3);
		case (r)
			0: send_request(OP_PUSH_FRONT, byte_t'($urandom_range(255)), POS_W'($urandom_range(127)));
			1: send_request(OP_PUSH_BACK, byte_t'($urandom_range(255)), POS_W'($urandom_range(127)));
			2: send_request(OP_INSERT, byte_t'($urandom_range(255)), pick_position(sb.shadow_len));
			default: send_request(OP_SORTED, byte_t'($urandom_range(255)),
				POS_W'($urandom_range(127)));
		endcase
	endtask

	task automatic send_drain_op();
		int r;
		r = $urandom_range(2);
		case (r)
			0: send_request(OP_POP_FRONT, byte_t'($urandom_range(255)), POS_W'($urandom_range(127)));
			1: send_request(OP_POP_BACK, byte_t'($urandom_range(255)), POS_W'($urandom_range(127)));
			default: send_request(OP_REMOVE, byte_t'($urandom_range(255)),
				pick_position(sb.shadow_len));
		endcase
	endtask

	task automatic send_mixed_op();
		logic [OPC_W-1:0] op;
		op = OPC_W'($urandom_range(OP_CLEAR));
		// keep clear rare so the store can grow
		if (op == OP_CLEAR && $urandom_range(3) != 0)
			op = OP_SORTED;
		send_request(op, byte_t'($urandom_range(255)), pick_position(sb.shadow_len));
	endtask

	task automatic run_random_phase(int n_items);
		int done;
		int kind;
		done = 0;
		while (done < n_items) begin
			kind = $urandom_range(9);
			if (kind < 2) begin
				while (sb.shadow_len < CAPACITY) begin
					send_fill_op();
					done++;
				end
				repeat ($urandom_range(3, 1)) begin
					send_fill_op();
					done++;
				end
			end else if (kind < 4) begin
				while (sb.shadow_len > 0) begin
					send_drain_op();
					done++;
				end
				repeat ($urandom_range(2, 1)) begin
					send_drain_op();
					done++;
				end
			end else if (kind < 9) begin
				repeat ($urandom_range(40, 4)) begin
					send_mixed_op();
					done++;
				end
			end else begin
				repeat ($urandom_range(3, 1)) begin
					send_request(OPC_W'($urandom_range(15, OP_CLEAR + 1)),
						byte_t'($urandom_range(255)), POS_W'($urandom_range(127)));
					done++;
				end
			end
		end
	endtask

	task automatic run_directed();
		send_request(OP_FIRST, 8'h00, 7'd0);
		send_request(OP_LAST, 8'hFF, 7'd0);
		send_request(OP_POP_FRONT, 8'h00, 7'd0);
		send_request(OP_POP_BACK, 8'h00, 7'd0);
		send_request(OP_READ, 8'h00, 7'd0);
		send_request(OP_REMOVE, 8'h00, 7'd0);
		send_request(OP_REPLACE, 8'hAA, 7'd0);
		send_request(OP_INSERT, 8'h11, 7'd1);
		send_request(OP_INSERT, 8'hFF, 7'd0);
		send_request(OP_PUSH_FRONT, 8'h00, 7'd0);
		send_request(OP_PUSH_BACK, 8'h80, 7'd0);
		send_request(OP_SORTED, 8'h7F, 7'd0);
		send_request(OP_READ, 8'h00, 7'd4);
		send_request(OP_READ, 8'h00, 7'd127);
		send_request(OP_READ, 8'h00, 7'd3);
		send_request(OP_FIRST, 8'h00, 7'd0);
		send_request(OP_LAST, 8'h00, 7'd0);
		send_request(OP_REPLACE, 8'h55, 7'd1);
		send_request(OP_REMOVE, 8'h00, 7'd0);
		send_request(OP_INSERT, 8'h01, 7'd3);
		send_request(OPC_W'(15), 8'hFF, 7'd127);
		send_request(OP_CLEAR, 8'h00, 7'd0);
		send_request(OP_PUSH_BACK, 8'h42, 7'd0);
		send_request(OP_POP_FRONT, 8'h00, 7'd0);
		send_request(OP_PUSH_BACK, 8'h24, 7'd0);
		send_request(OP_POP_BACK, 8'h00, 7'd0);
	endtask

	initial begin
		arst_n       <= 1'b0;
		req.valid    <= 1'b0;
		req.opcode   <= '0;
		req.ch       <= '0;
		req.position <= '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();

		src_idle_pct   = 0;
		sink_stall_pct = 0;
		run_random_phase(PHASE_ITEMS);
		src_idle_pct   = 69;
		sink_stall_pct = 0;
		run_random_phase(PHASE_ITEMS);
		src_idle_pct   = 0;
		sink_stall_pct = 69;
		run_random_phase(PHASE_ITEMS);
		src_idle_pct   = 23;
		sink_stall_pct = 23;
		run_random_phase(PHASE_ITEMS);

		req.valid <= 1'b0;
		while (sb.expected_rsp_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (sb.mismatches == 0 && sb.expected_rsp_q.size() == 0)
			$display("indexed_char_sequence_store_core_tb OK");
		else
			$display("indexed_char_sequence_store_core_tb NOT OK");
		$finish;
	end

endmodule
